// ----- rtl/core/psre_pkg.sv -----
// Shared types, constants and helper functions for the pixel symbol RLE encoder.
package psre_pkg;

    localparam logic [6:0] CHAR_BAR   = 7'h7C;
    localparam logic [7:0] RUN_SAT    = 8'd255;

    typedef enum logic [3:0] {
        SLOT_PRE_H  = 4'd0,
        SLOT_PRE_T  = 4'd1,
        SLOT_PRE_O  = 4'd2,
        SLOT_BAR_L  = 4'd3,
        SLOT_ROW_H  = 4'd4,
        SLOT_ROW_T  = 4'd5,
        SLOT_ROW_O  = 4'd6,
        SLOT_BAR_R  = 4'd7,
        SLOT_SYM    = 4'd8,
        SLOT_POST_H = 4'd9,
        SLOT_POST_T = 4'd10,
        SLOT_POST_O = 4'd11
    } psre_slot_t;

    localparam int SLOT_COUNT = 12;

    typedef struct packed {
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] o;
    } psre_dec_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] mask;
        psre_dec_t             pre;
        psre_dec_t             row;
        logic [5:0]            sym;
        psre_dec_t             post;
    } psre_cmd_t;

    // three decimal digits of an 8-bit value, tens by reciprocal multiply
    function automatic psre_dec_t to_dec(input logic [7:0] v);
        psre_dec_t  d;
        logic [7:0] r;
        logic [14:0] prod;
        logic [6:0] tens_x10;
        if (v >= 8'd200) begin
            d.h = 4'd2;
            r   = v - 8'd200;
        end else if (v >= 8'd100) begin
            d.h = 4'd1;
            r   = v - 8'd100;
        end else begin
            d.h = 4'd0;
            r   = v;
        end
        prod     = {8'd0, r[6:0]} * 15'd205;
        d.t      = prod[14:11];
        tens_x10 = 7'(d.t) * 7'd10;
        d.o      = 4'(r[6:0] - tens_x10);
        return d;
    endfunction

    // digit enables {ones, tens, hundreds} of an 8-bit value, no leading zeros
    function automatic logic [2:0] dec_mask(input logic [7:0] v);
        logic [2:0] m;
        m[0] = (v >= 8'd100);
        m[1] = (v >= 8'd10);
        m[2] = 1'b1;
        return m;
    endfunction

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        return {3'b011, d};
    endfunction

    function automatic logic [6:0] sym_char(input logic [5:0] s);
        logic [6:0] c;
        if (s < 6'd26) begin
            c = 7'h61 + 7'(s);
        end else if (s < 6'd52) begin
            c = 7'h41 + 7'(s - 6'd26);
        end else begin
            case (s)
                6'd52:   c = 7'h21;
                6'd53:   c = 7'h40;
                6'd54:   c = 7'h23;
                6'd55:   c = 7'h24;
                6'd56:   c = 7'h25;
                6'd57:   c = 7'h5E;
                6'd58:   c = 7'h26;
                6'd59:   c = 7'h2A;
                6'd60:   c = 7'h28;
                6'd61:   c = 7'h29;
                6'd62:   c = 7'h2D;
                default: c = 7'h5F;
            endcase
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/psre_front.sv -----
// Front end: tracks the open run; pixels with output yield character commands.
module psre_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        pixel,
    input  logic [6:0]        row_number,
    input  logic              first_in_row,
    input  logic              last_of_plane,
    input  logic              q_full,
    output logic              q_push,
    output psre_pkg::psre_cmd_t q_data
);
    import psre_pkg::*;

    logic [5:0] run_symbol_reg, run_symbol_next;
    logic       run_valid_reg, run_valid_next;
    logic [7:0] run_length_reg, run_length_next;

    logic [5:0] sym;
    logic       accept;
    logic       cont;
    logic       pre_en;
    logic       post_en;
    logic [7:0] len_after;
    logic [2:0] pre_m, row_m, post_m;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sym      = pixel[7:2];

    always_comb
    begin
        cont      = run_valid_reg && !first_in_row && (sym == run_symbol_reg);
        pre_en    = run_valid_reg && (run_length_reg >= 8'd2) && !cont;
        len_after = cont ? ((run_length_reg < RUN_SAT) ? run_length_reg + 8'd1
                                                       : run_length_reg)
                         : 8'd1;
        post_en   = last_of_plane && (len_after >= 8'd2);

        pre_m  = dec_mask(run_length_reg);
        row_m  = dec_mask({1'b0, row_number});
        post_m = dec_mask(len_after);

        q_data.pre  = to_dec(run_length_reg);
        q_data.row  = to_dec({1'b0, row_number});
        q_data.post = to_dec(len_after);
        q_data.sym  = sym;

        q_data.mask              = '0;
        q_data.mask[SLOT_PRE_H]  = pre_en && pre_m[0];
        q_data.mask[SLOT_PRE_T]  = pre_en && pre_m[1];
        q_data.mask[SLOT_PRE_O]  = pre_en && pre_m[2];
        q_data.mask[SLOT_BAR_L]  = first_in_row;
        q_data.mask[SLOT_ROW_H]  = first_in_row && row_m[0];
        q_data.mask[SLOT_ROW_T]  = first_in_row && row_m[1];
        q_data.mask[SLOT_ROW_O]  = first_in_row && row_m[2];
        q_data.mask[SLOT_BAR_R]  = first_in_row;
        q_data.mask[SLOT_SYM]    = !cont;
        q_data.mask[SLOT_POST_H] = post_en && post_m[0];
        q_data.mask[SLOT_POST_T] = post_en && post_m[1];
        q_data.mask[SLOT_POST_O] = post_en && post_m[2];

        q_push = accept && (q_data.mask != '0);

        run_symbol_next = run_symbol_reg;
        run_valid_next  = run_valid_reg;
        run_length_next = run_length_reg;
        if (accept) begin
            run_symbol_next = sym;
            run_valid_next  = !last_of_plane;
            run_length_next = last_of_plane ? 8'd0 : len_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_symbol_reg <= '0;
            run_valid_reg  <= 1'b0;
            run_length_reg <= '0;
        end else begin
            run_symbol_reg <= run_symbol_next;
            run_valid_reg  <= run_valid_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule

// ----- rtl/core/psre_queue.sv -----
// Small register FIFO carrying character commands from front to back end.
module psre_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  psre_pkg::psre_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output psre_pkg::psre_cmd_t pop_data
);
    import psre_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    psre_cmd_t     store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_ONE;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/psre_back.sv -----
// Back end: walks a command's slots, one character per cycle unless stalled.
module psre_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  psre_pkg::psre_cmd_t q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          text_char,
    output logic                last_char
);
    import psre_pkg::*;

    psre_cmd_t             cur_reg, cur_next;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            text_char_reg, text_char_next;
    logic                  last_char_reg, last_char_next;

    psre_slot_t            sel;
    logic [SLOT_COUNT-1:0] remaining;
    logic                  advance;
    logic                  emit;
    logic [6:0]            ch;

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

    always_comb
    begin
        sel = SLOT_POST_O;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (cur_reg.mask[i]) begin
                sel = psre_slot_t'(i[3:0]);
            end
        end
        remaining      = cur_reg.mask;
        remaining[sel] = 1'b0;

        case (sel)
            SLOT_PRE_H:  ch = digit_char(cur_reg.pre.h);
            SLOT_PRE_T:  ch = digit_char(cur_reg.pre.t);
            SLOT_PRE_O:  ch = digit_char(cur_reg.pre.o);
            SLOT_BAR_L:  ch = CHAR_BAR;
            SLOT_ROW_H:  ch = digit_char(cur_reg.row.h);
            SLOT_ROW_T:  ch = digit_char(cur_reg.row.t);
            SLOT_ROW_O:  ch = digit_char(cur_reg.row.o);
            SLOT_BAR_R:  ch = CHAR_BAR;
            SLOT_SYM:    ch = sym_char(cur_reg.sym);
            SLOT_POST_H: ch = digit_char(cur_reg.post.h);
            SLOT_POST_T: ch = digit_char(cur_reg.post.t);
            SLOT_POST_O: ch = digit_char(cur_reg.post.o);
            default:     ch = CHAR_BAR;
        endcase

        advance = !out_valid_reg || out_ready;
        emit    = advance && (cur_reg.mask != '0);

        out_valid_next = out_valid_reg;
        text_char_next = text_char_reg;
        last_char_next = last_char_reg;
        if (advance) begin
            out_valid_next = emit;
            text_char_next = ch;
            last_char_next = (remaining == '0);
        end

        // take the next command once the current one is spent
        q_pop = q_not_empty && ((cur_reg.mask == '0) || (emit && (remaining == '0)));

        cur_next = cur_reg;
        if (q_pop) begin
            cur_next = q_data;
        end else if (emit) begin
            cur_next.mask = remaining;
        end
    end

    always_ff @(posedge clk)
    begin
        text_char_reg  <= text_char_next;
        last_char_reg  <= last_char_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/pixel_symbol_rle_encoder_top.sv -----
// Top level of the pixel symbol RLE encoder: front end, command queue, back end.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | pixel, row_number, first_in_row, last_of_plane
//  out     | out_valid / out_ready| text_char, last_char
//
// A request is taken every cycle while the command queue has room; each pixel
// yields 0 to 9 characters, and the back end sends one character per cycle
// while out_ready is high. Commands pass the queue and the back-end command
// register, and the characters leave through a registered output.
// Reset clears the open run, queue pointers, back-end command and out_valid.
// Output stalls fill the queue and then hold in_ready low.
module pixel_symbol_rle_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] pixel,
    input  logic [6:0] row_number,
    input  logic       first_in_row,
    input  logic       last_of_plane,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] text_char,
    output logic       last_char
);
    import psre_pkg::*;

    psre_cmd_t push_data;
    psre_cmd_t pop_data;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;

    psre_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel         (pixel),
        .row_number    (row_number),
        .first_in_row  (first_in_row),
        .last_of_plane (last_of_plane),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (push_data)
    );

    psre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    psre_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .text_char   (text_char),
        .last_char   (last_char)
    );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the pixel symbol RLE encoder: directed and random pixel streams.
`timescale 1ns / 100ps

module tb_top;
    import psre_pkg::*;

    typedef struct {
        logic [7:0] pix;
        logic [6:0] row;
        logic       first;
        logic       last;
        bit         drain;
    } pixel_req_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       fin;
    } text_char_t;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_LIMIT = 20000;
    localparam int         TAIL_CYCLES = 12;
    localparam int         CALM_ITEMS  = 30;
    localparam int         RAND_ITEMS  = 24;
    localparam logic [6:0] CHAR_ZERO   = 7'h30;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic [7:0] pixel         = '0;
    logic [6:0] row_number    = '0;
    logic       first_in_row  = 1'b0;
    logic       last_of_plane = 1'b0;
    logic       out_ready     = 1'b0;
    wire        in_ready;
    wire        out_valid;
    wire  [6:0] text_char;
    wire        last_char;

    pixel_symbol_rle_encoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel         (pixel),
        .row_number    (row_number),
        .first_in_row  (first_in_row),
        .last_of_plane (last_of_plane),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .text_char     (text_char),
        .last_char     (last_char)
    );

    string glyphs = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()-_";

    pixel_req_t pend_q[$];
    text_char_t text_q[$];
    logic [6:0] pix_text[$];

    logic [5:0] run_sym  = '0;
    logic       run_open = 1'b0;
    logic [7:0] run_len  = '0;

    bit in_fire    = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;
    int err_count  = 0;
    int chars_seen = 0;
    int pixels_in  = 0;
    int rows_in    = 0;
    int cycles     = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void put_count(input logic [7:0] v);
        if (v >= 8'd100)
            pix_text.push_back(CHAR_ZERO + 7'(v / 100));
        if (v >= 8'd10)
            pix_text.push_back(CHAR_ZERO + 7'((v / 10) % 10));
        pix_text.push_back(CHAR_ZERO + 7'(v % 10));
    endfunction

    function automatic void close_count();
        if (run_open && run_len >= 8'd2)
            put_count(run_len);
    endfunction

    function automatic void encode_pixel(input pixel_req_t r);
        logic [5:0] s;
        s = r.pix[7:2];
        pix_text.delete();
        if (r.first)
        begin
            close_count();
            run_open = 1'b0;
            run_len  = '0;
            pix_text.push_back(CHAR_BAR);
            put_count({1'b0, r.row});
            pix_text.push_back(CHAR_BAR);
            rows_in++;
        end
        if (run_open && s == run_sym)
        begin
            if (run_len != RUN_SAT)
                run_len++;
        end
        else
        begin
            close_count();
            run_sym  = s;
            run_open = 1'b1;
            run_len  = 8'd1;
            pix_text.push_back(7'(glyphs[s]));
        end
        if (r.last)
        begin
            close_count();
            run_open = 1'b0;
            run_len  = '0;
        end
        foreach (pix_text[i])
            text_q.push_back({pix_text[i], i == pix_text.size() - 1});
    endfunction

    task automatic add_req(input logic [7:0] p, input logic [6:0] r, input logic f,
                           input logic l, input bit d = 1'b0);
        pixel_req_t q;
        q.pix   = p;
        q.row   = r;
        q.first = f;
        q.last  = l;
        q.drain = d;
        pend_q.push_back(q);
    endtask

    // checker and predictor, sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        text_char_t exp;
        pixel_req_t got;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                chars_seen++;
                if (text_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected char %h last %b", $realtime, text_char,
                                 last_char);
                end
                else
                begin
                    exp = text_q.pop_front();
                    if (exp.ch !== text_char || exp.fin !== last_char)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: char exp %h/%b got %h/%b", $realtime, exp.ch,
                                     exp.fin, text_char, last_char);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                got.pix   = pixel;
                got.row   = row_number;
                got.first = first_in_row;
                got.last  = last_of_plane;
                got.drain = 1'b0;
                encode_pixel(got);
                pixels_in++;
            end
            in_fire <= in_valid && in_ready;
        end
    end

    // request driver and output stall generator, on the falling edge
    always @(negedge clk)
    begin : driver
        pixel_req_t nxt;
        logic       v;
        bit         calm;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            calm = pend_q.size() < CALM_ITEMS;
            v = in_valid;
            if (in_valid && in_fire)
            begin
                v = 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            if (!v)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pend_q.size() > 0 && !(pend_q[0].drain && text_q.size() != 0))
                begin
                    nxt = pend_q.pop_front();
                    pixel         <= nxt.pix;
                    row_number    <= nxt.row;
                    first_in_row  <= nxt.first;
                    last_of_plane <= nxt.last;
                    v = 1'b1;
                end
            end
            in_valid <= v;

            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int         n;
        int         k;
        int         len;
        int         row_len;
        int         rows_built;
        int         waited;
        logic [5:0] s;
        logic [6:0] r;
        bit         plane_end;

        // directed
        add_req(8'h80, 7'd0, 1'b0, 1'b0);
        add_req(8'h83, 7'd0, 1'b0, 1'b0);
        add_req(8'h00, 7'd0, 1'b1, 1'b0);
        add_req(8'hFF, 7'd0, 1'b0, 1'b0);
        add_req(8'hFC, 7'd0, 1'b0, 1'b0);
        add_req(8'hFD, 7'd0, 1'b0, 1'b1);
        add_req(8'h7F, 7'd127, 1'b1, 1'b1);
        add_req(8'h40, 7'd9, 1'b1, 1'b0);
        add_req(8'h41, 7'd9, 1'b0, 1'b0);
        add_req(8'h42, 7'd10, 1'b1, 1'b0);
        add_req(8'h64, 7'd10, 1'b0, 1'b0);
        add_req(8'h68, 7'd10, 1'b0, 1'b0);
        add_req(8'hCC, 7'd10, 1'b0, 1'b0);
        add_req(8'hD0, 7'd10, 1'b0, 1'b0);
        add_req(8'hD3, 7'd10, 1'b0, 1'b1);
        add_req(8'h55, 7'd99, 1'b0, 1'b0);
        add_req(8'h55, 7'd99, 1'b1, 1'b0);
        add_req(8'h56, 7'd100, 1'b1, 1'b0);
        add_req(8'hAA, 7'd100, 1'b0, 1'b0);
        add_req(8'hAA, 7'd100, 1'b0, 1'b1);
        add_req(8'h01, 7'd1, 1'b0, 1'b1);

        // one row sweeping every symbol, opened only once the output is idle
        for (k = 0; k < 64; k++)
            add_req({6'(k), 2'($urandom)}, 7'd2, k == 0, k == 63, k == 0);

        n = 0;
        r = '0;
        s = '0;
        rows_built = 0;
        while (n < RAND_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_req(8'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
                n++;
            end
            else
            begin
                r = ($urandom_range(0, 4) == 0) ? 7'($urandom) : r + 7'd1;
                row_len = $urandom_range(1, 12);
                plane_end = ($urandom_range(0, 3) == 0);
                k = 0;
                while (k < row_len)
                begin
                    if ($urandom_range(0, 2) != 0)
                        s = 6'($urandom);
                    len = $urandom_range(1, 4);
                    if (len > row_len - k)
                        len = row_len - k;
                    repeat (len)
                    begin
                        add_req({s, 2'($urandom)}, r, k == 0, plane_end && k == row_len - 1,
                                k == 0 && rows_built % 7 == 3);
                        k++;
                        n++;
                    end
                end
                rows_built++;
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pend_q.size() != 0 || in_valid)
            @(posedge clk);
        waited = 0;
        while (text_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (text_q.size() != 0)
        begin
            err_count++;
            $display("%0d expected chars never arrived", text_q.size());
        end

        $display("Encoded %0d pixels over %0d row headers; %0d chars checked, %0d mismatches",
                 pixels_in, rows_in, chars_seen, err_count);
        $display("Covered every symbol, 3-digit rows, joint row and plane marks, plane flushes");
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/psre_pkg.sv
rtl/core/psre_front.sv
rtl/core/psre_queue.sv
rtl/core/psre_back.sv
rtl/core/pixel_symbol_rle_encoder_top.sv
bench/tb_top.sv
